### src/iace_pkg.sv
// Shared types, constants and lookup functions for the IMA ADPCM clip encoder.
package iace_pkg;

    localparam int LOOKAHEAD_DEPTH_DEF = 16;
    localparam int QUEUE_DEPTH         = 4;
    localparam int IDX_W               = 7;
    localparam int STEP_W              = 15;
    localparam int DELTA_W             = 17;
    localparam int REC_W               = 16;
    localparam int INDEX_MAX           = 88;

    localparam logic [IDX_W-1:0]  INDEX_LAST = IDX_W'(INDEX_MAX);
    localparam logic [STEP_W-1:0] STEP_TOP   = 15'd32767;

    // Input beat and result beat payloads
    typedef struct packed {
        logic signed [15:0] sample;
        logic               last_sample;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_is_header;
        logic       out_last;
    } out_t;

    // Command passed from the front end to the encoder back end
    typedef struct packed {
        logic               is_header;
        logic signed [15:0] sample;
        logic [IDX_W-1:0]   index;
        logic               is_final;
    } cmd_t;

    typedef enum logic [2:0] {
        F_LOOK,
        F_SEARCH,
        F_HEAD,
        F_READ,
        F_PUSH,
        F_STREAM
    } front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_HDR,
        B_CALC,
        B_UPD
    } back_state_t;

    typedef enum logic [1:0] {
        HB_PRED_LO,
        HB_PRED_HI,
        HB_INDEX_LO,
        HB_INDEX_HI
    } hdr_byte_t;

    localparam logic [STEP_W-1:0] STEP_TABLE [0:INDEX_MAX] = '{
        15'd7,     15'd8,     15'd9,     15'd10,    15'd11,    15'd12,    15'd13,
        15'd14,    15'd16,    15'd17,    15'd19,    15'd21,    15'd23,    15'd25,
        15'd28,    15'd31,    15'd34,    15'd37,    15'd41,    15'd45,    15'd50,
        15'd55,    15'd60,    15'd66,    15'd73,    15'd80,    15'd88,    15'd97,
        15'd107,   15'd118,   15'd130,   15'd143,   15'd157,   15'd173,   15'd190,
        15'd209,   15'd230,   15'd253,   15'd279,   15'd307,   15'd337,   15'd371,
        15'd408,   15'd449,   15'd494,   15'd544,   15'd598,   15'd658,   15'd724,
        15'd796,   15'd876,   15'd963,   15'd1060,  15'd1166,  15'd1282,  15'd1411,
        15'd1552,  15'd1707,  15'd1878,  15'd2066,  15'd2272,  15'd2499,  15'd2749,
        15'd3024,  15'd3327,  15'd3660,  15'd4026,  15'd4428,  15'd4871,  15'd5358,
        15'd5894,  15'd6484,  15'd7132,  15'd7845,  15'd8630,  15'd9493,  15'd10442,
        15'd11487, 15'd12635, 15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350,
        15'd22385, 15'd24623, 15'd27086, 15'd29794, 15'd32767
    };

    // Step size for a quantizer index; indexes past the table read the top step
    function automatic logic [STEP_W-1:0] step_size(input logic [IDX_W-1:0] idx);
        logic [STEP_W-1:0] s;
        if (idx > INDEX_LAST) begin
            s = STEP_TOP;
        end else begin
            s = STEP_TABLE[idx];
        end
        return s;
    endfunction

    // Threshold step*15/8 used to pick the starting index
    function automatic logic [DELTA_W-1:0] step_threshold(input logic [IDX_W-1:0] idx);
        logic [18:0] p;
        p = {4'b0000, step_size(idx)} * 19'd15;
        return {1'b0, p[18:3]};
    endfunction

    // Index adjustment for a nibble, sign bit ignored
    function automatic logic signed [4:0] index_move(input logic [3:0] nib);
        logic signed [4:0] m;
        case (nib[2:0])
            3'd4:    m = 5'sd2;
            3'd5:    m = 5'sd4;
            3'd6:    m = 5'sd6;
            3'd7:    m = 5'sd8;
            default: m = -5'sd1;
        endcase
        return m;
    endfunction

endpackage

### src/iace_front.sv
// Front end: lookahead buffering, start index search and command issue.
module iace_front #(
    parameter int DEPTH = iace_pkg::LOOKAHEAD_DEPTH_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  iace_pkg::in_t s_data,
    output logic          q_valid,
    input  logic          q_ready,
    output iace_pkg::cmd_t q_data
);
    import iace_pkg::*;

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    front_state_t state_reg, state_next;
    logic [ADDR_W-1:0]  count_reg, count_next;
    logic [ADDR_W-1:0]  last_addr_reg, last_addr_next;
    logic [ADDR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic               flush_final_reg, flush_final_next;
    logic signed [15:0] prev_reg, prev_next;
    logic signed [15:0] first_reg, first_next;
    logic [DELTA_W-1:0] delta_reg, delta_next;
    logic [IDX_W-1:0]   lo_reg, lo_next;
    logic [IDX_W-1:0]   hi_reg, hi_next;
    logic signed [15:0] rdata_reg;
    logic signed [15:0] mem [0:DEPTH-1];

    logic signed [DELTA_W-1:0] diff;
    logic [DELTA_W-1:0]        mag;
    logic [DELTA_W-1:0]        delta_upd;
    logic [IDX_W:0]            mid_sum;
    logic [IDX_W-1:0]          mid;
    logic                      thr_ok;

    // Neighbor difference and running maximum
    always_comb begin
        diff = {s_data.sample[15], s_data.sample} - {prev_reg[15], prev_reg};
        mag  = diff[DELTA_W-1] ? DELTA_W'(-diff) : DELTA_W'(diff);
        delta_upd = ((count_reg != '0) && (mag > delta_reg)) ? mag : delta_reg;
    end

    // Binary search probe
    always_comb begin
        mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
        mid     = mid_sum[IDX_W:1];
        thr_ok  = step_threshold(mid) >= delta_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= F_LOOK;
            count_reg       <= '0;
            delta_reg       <= '0;
            flush_final_reg <= 1'b0;
        end else begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            delta_reg       <= delta_next;
            flush_final_reg <= flush_final_next;
        end
    end

    always_ff @(posedge aclk) begin
        last_addr_reg <= last_addr_next;
        rd_ptr_reg    <= rd_ptr_next;
        prev_reg      <= prev_next;
        first_reg     <= first_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
    end

    // Lookahead store: write on buffered beats, registered read while draining
    always_ff @(posedge aclk) begin
        if (state_reg == F_LOOK && s_valid) begin
            mem[count_reg] <= s_data.sample;
        end
        if (state_reg == F_READ) begin
            rdata_reg <= mem[rd_ptr_reg];
        end
    end

    always_comb begin
        state_next       = state_reg;
        count_next       = count_reg;
        last_addr_next   = last_addr_reg;
        rd_ptr_next      = rd_ptr_reg;
        flush_final_next = flush_final_reg;
        prev_next        = prev_reg;
        first_next       = first_reg;
        delta_next       = delta_reg;
        lo_next          = lo_reg;
        hi_next          = hi_reg;
        s_ready          = 1'b0;
        q_valid          = 1'b0;
        q_data           = '0;

        unique case (state_reg)
            F_LOOK: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    prev_next  = s_data.sample;
                    delta_next = delta_upd;
                    count_next = count_reg + 1'b1;
                    if (count_reg == '0) begin
                        first_next = s_data.sample;
                    end
                    // Flush when the store fills or the clip ends
                    if (s_data.last_sample || count_reg == LAST_ADDR) begin
                        last_addr_next   = count_reg;
                        flush_final_next = s_data.last_sample;
                        count_next       = '0;
                        lo_next          = '0;
                        hi_next          = INDEX_LAST;
                        state_next       = F_SEARCH;
                    end
                end
            end
            F_SEARCH: begin
                if (lo_reg == hi_reg) begin
                    state_next = F_HEAD;
                end else if (thr_ok) begin
                    hi_next = mid;
                end else begin
                    lo_next = mid + 1'b1;
                end
            end
            F_HEAD: begin
                q_valid          = 1'b1;
                q_data.is_header = 1'b1;
                q_data.sample    = first_reg;
                q_data.index     = lo_reg;
                if (q_ready) begin
                    delta_next  = '0;
                    rd_ptr_next = '0;
                    state_next  = F_READ;
                end
            end
            F_READ: begin
                state_next = F_PUSH;
            end
            F_PUSH: begin
                q_valid         = 1'b1;
                q_data.sample   = rdata_reg;
                q_data.is_final = flush_final_reg && (rd_ptr_reg == last_addr_reg);
                if (q_ready) begin
                    if (rd_ptr_reg == last_addr_reg) begin
                        state_next = flush_final_reg ? F_LOOK : F_STREAM;
                    end else begin
                        rd_ptr_next = rd_ptr_reg + 1'b1;
                        state_next  = F_READ;
                    end
                end
            end
            F_STREAM: begin
                s_ready         = q_ready;
                q_valid         = s_valid;
                q_data.sample   = s_data.sample;
                q_data.is_final = s_data.last_sample;
                if (s_valid && q_ready && s_data.last_sample) begin
                    state_next = F_LOOK;
                end
            end
            default: begin
                state_next = F_LOOK;
            end
        endcase
    end

endmodule

### src/iace_queue.sv
// Short command queue between the front end and the encoder back end.
module iace_queue #(
    parameter int DEPTH = iace_pkg::QUEUE_DEPTH
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push_valid,
    output logic           push_ready,
    input  iace_pkg::cmd_t push_data,
    output logic           pop_valid,
    input  logic           pop_ready,
    output iace_pkg::cmd_t pop_data
);
    import iace_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    cmd_t             slot_reg [0:DEPTH-1];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             do_push;
    logic             do_pop;

    always_comb begin
        push_ready = fill_reg != CNT_FULL;
        pop_valid  = fill_reg != '0;
        pop_data   = slot_reg[rd_ptr_reg];
        do_push    = push_valid && push_ready;
        do_pop     = pop_valid && pop_ready;
    end

    // Advance pointers and fill level
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### src/iace_back.sv
// Back end: header emission, ADPCM quantization and nibble packing.
module iace_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_valid,
    output logic           q_ready,
    input  iace_pkg::cmd_t q_data,
    output logic           m_valid,
    input  logic           m_ready,
    output iace_pkg::out_t m_data
);
    import iace_pkg::*;

    back_state_t state_reg, state_next;
    hdr_byte_t   hdr_cnt_reg, hdr_cnt_next;
    logic signed [15:0] pred_reg, pred_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic signed [15:0] sample_reg, sample_next;
    logic               final_reg, final_next;
    logic [3:0]         nib_reg, nib_next;
    logic [REC_W-1:0]   rec_reg, rec_next;
    logic [3:0]         held_reg, held_next;
    logic               waiting_reg, waiting_next;
    logic               m_valid_reg, m_valid_next;
    out_t               m_data_reg, m_data_next;

    logic [STEP_W-1:0]         step;
    logic signed [DELTA_W-1:0] diff;
    logic [DELTA_W-1:0]        mag;
    logic [DELTA_W-1:0]        rec_calc;
    logic [3:0]                nib_calc;
    logic signed [17:0]        pred_sum;
    logic signed [15:0]        pred_sat;
    logic signed [8:0]         idx_sum;
    logic [IDX_W-1:0]          idx_clamped;
    logic                      out_free;

    // Quantize one sample against the running predictor
    always_comb begin
        step     = step_size(idx_reg);
        diff     = {sample_reg[15], sample_reg} - {pred_reg[15], pred_reg};
        nib_calc = {diff[DELTA_W-1], 3'b000};
        mag      = diff[DELTA_W-1] ? DELTA_W'(-diff) : DELTA_W'(diff);
        rec_calc = DELTA_W'(step >> 3);
        if (mag >= DELTA_W'(step)) begin
            nib_calc[2] = 1'b1;
            mag         = mag - DELTA_W'(step);
            rec_calc    = rec_calc + DELTA_W'(step);
        end
        if (mag >= DELTA_W'(step >> 1)) begin
            nib_calc[1] = 1'b1;
            mag         = mag - DELTA_W'(step >> 1);
            rec_calc    = rec_calc + DELTA_W'(step >> 1);
        end
        if (mag >= DELTA_W'(step >> 2)) begin
            nib_calc[0] = 1'b1;
            rec_calc    = rec_calc + DELTA_W'(step >> 2);
        end
    end

    // Saturate the predictor and clamp the index
    always_comb begin
        if (nib_reg[3]) begin
            pred_sum = {{2{pred_reg[15]}}, pred_reg} - $signed({2'b00, rec_reg});
        end else begin
            pred_sum = {{2{pred_reg[15]}}, pred_reg} + $signed({2'b00, rec_reg});
        end
        if (pred_sum > 18'sd32767) begin
            pred_sat = 16'sh7FFF;
        end else if (pred_sum < -18'sd32768) begin
            pred_sat = 16'sh8000;
        end else begin
            pred_sat = pred_sum[15:0];
        end
        idx_sum = $signed({2'b00, idx_reg}) + 9'(index_move(nib_reg));
        if (idx_sum < 9'sd0) begin
            idx_clamped = '0;
        end else if (idx_sum > $signed({2'b00, INDEX_LAST})) begin
            idx_clamped = INDEX_LAST;
        end else begin
            idx_clamped = idx_sum[IDX_W-1:0];
        end
    end

    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            hdr_cnt_reg <= HB_PRED_LO;
            waiting_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            hdr_cnt_reg <= hdr_cnt_next;
            waiting_reg <= waiting_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pred_reg   <= pred_next;
        idx_reg    <= idx_next;
        sample_reg <= sample_next;
        final_reg  <= final_next;
        nib_reg    <= nib_next;
        rec_reg    <= rec_next;
        held_reg   <= held_next;
        m_data_reg <= m_data_next;
    end

    always_comb begin
        state_next   = state_reg;
        hdr_cnt_next = hdr_cnt_reg;
        pred_next    = pred_reg;
        idx_next     = idx_reg;
        sample_next  = sample_reg;
        final_next   = final_reg;
        nib_next     = nib_reg;
        rec_next     = rec_reg;
        held_next    = held_reg;
        waiting_next = waiting_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        q_ready      = 1'b0;

        unique case (state_reg)
            B_IDLE: begin
                q_ready = 1'b1;
                if (q_valid) begin
                    if (q_data.is_header) begin
                        pred_next    = q_data.sample;
                        idx_next     = q_data.index;
                        hdr_cnt_next = HB_PRED_LO;
                        state_next   = B_HDR;
                    end else begin
                        sample_next = q_data.sample;
                        final_next  = q_data.is_final;
                        state_next  = B_CALC;
                    end
                end
            end
            B_HDR: begin
                if (out_free) begin
                    m_valid_next               = 1'b1;
                    m_data_next.byte_is_header = 1'b1;
                    m_data_next.out_last       = 1'b0;
                    unique case (hdr_cnt_reg)
                        HB_PRED_LO:  m_data_next.out_byte = pred_reg[7:0];
                        HB_PRED_HI:  m_data_next.out_byte = pred_reg[15:8];
                        HB_INDEX_LO: m_data_next.out_byte = {1'b0, idx_reg};
                        HB_INDEX_HI: m_data_next.out_byte = 8'h00;
                        default:     m_data_next.out_byte = 8'h00;
                    endcase
                    if (hdr_cnt_reg == HB_INDEX_HI) begin
                        state_next = B_IDLE;
                    end else begin
                        hdr_cnt_next = hdr_byte_t'(hdr_cnt_reg + 2'd1);
                    end
                end
            end
            B_CALC: begin
                nib_next   = nib_calc;
                rec_next   = rec_calc[REC_W-1:0];
                state_next = B_UPD;
            end
            B_UPD: begin
                if (out_free) begin
                    pred_next  = pred_sat;
                    idx_next   = idx_clamped;
                    state_next = B_IDLE;
                    // Pack nibbles low half first; pad an odd final nibble
                    if (waiting_reg) begin
                        m_valid_next               = 1'b1;
                        m_data_next.out_byte       = {nib_reg, held_reg};
                        m_data_next.byte_is_header = 1'b0;
                        m_data_next.out_last       = final_reg;
                        waiting_next               = 1'b0;
                    end else if (final_reg) begin
                        m_valid_next               = 1'b1;
                        m_data_next.out_byte       = {4'h0, nib_reg};
                        m_data_next.byte_is_header = 1'b0;
                        m_data_next.out_last       = 1'b1;
                    end else begin
                        held_next    = nib_reg;
                        waiting_next = 1'b1;
                    end
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

endmodule

### src/ima_adpcm_clip_encoder.sv
// IMA ADPCM clip encoder top level: front end, command queue and back end.
// Lookahead: one sample per cycle until the store fills or the clip ends.
// Flush: a binary search for the start index, 4 header bytes, then each buffered sample
//   passes the back end's idle, quantize and update states (front drains via read, push).
// Streaming after the lookahead: the back end takes a new sample only in idle, after
//   quantize and update of the last; a byte is registered at its last sample's update.
// Reset (aresetn low, synchronous) clears all control state; the store is not cleared.
module ima_adpcm_clip_encoder #(
    parameter int LOOKAHEAD_DEPTH = iace_pkg::LOOKAHEAD_DEPTH_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  iace_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output iace_pkg::out_t m_data
);
    import iace_pkg::*;

    logic fq_valid;
    logic fq_ready;
    cmd_t fq_data;
    logic qb_valid;
    logic qb_ready;
    cmd_t qb_data;

    iace_front #(
        .DEPTH(LOOKAHEAD_DEPTH)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (fq_valid),
        .q_ready (fq_ready),
        .q_data  (fq_data)
    );

    iace_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_data  (fq_data),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_data   (qb_data)
    );

    iace_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (qb_valid),
        .q_ready (qb_ready),
        .q_data  (qb_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

### src/iace_checker.sv
// Port-level checks on the encoder's result stream, bound to the top level.
module iace_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           m_valid,
    input logic           m_ready,
    input iace_pkg::out_t m_data
);
    import iace_pkg::*;

    logic [2:0] hdr_run_reg, hdr_run_next;

    // Count consecutive header beats
    always_comb begin
        hdr_run_next = hdr_run_reg;
        if (m_valid && m_ready) begin
            if (!m_data.byte_is_header) begin
                hdr_run_next = '0;
            end else if (hdr_run_reg != 3'd7) begin
                hdr_run_next = hdr_run_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_run_reg <= '0;
        end else begin
            hdr_run_reg <= hdr_run_next;
        end
    end

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result valid dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_data))
        else $error("result payload changed while stalled");

    a_hdr_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.byte_is_header && m_data.out_last))
        else $error("header byte marked as last");

    a_hdr_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.byte_is_header && hdr_run_reg != 3'd0 |-> hdr_run_reg == 3'd4)
        else $error("header run not four bytes");

    a_hdr_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.byte_is_header |-> hdr_run_reg < 3'd4)
        else $error("header run longer than four bytes");

endmodule

bind ima_adpcm_clip_encoder iace_checker u_iace_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
